@@ rtl/core/sha256_stream_hasher_core_assert.svh @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core_assert.svh
// Assertion macros used by the hasher core RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SHASH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SHASH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/shash_pkg.sv @@
// ----------------------------------------------------------------------------
// shash_pkg
// Types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shash_pkg;

    localparam int WORD_W     = 32;
    localparam int HASH_DEPTH = 8;
    localparam int HASH_AW    = 3;
    localparam int BUF_DEPTH  = 16;
    localparam int BUF_AW     = 4;
    localparam int FILL_W     = 6;
    localparam int TOTAL_W    = 61;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] HASH_INIT [HASH_DEPTH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] msg_word;
        logic [2:0]  byte_count;
        logic        is_last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic [BUF_AW-1:0] pad_idx;
        logic [31:0]       pad_word;
        logic [63:0]       bit_len;
        logic              late_pad;
    } t_fill_info;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [31:0]       data;
    } t_buf_wr;

    typedef struct packed {
        logic               we;
        logic [HASH_AW-1:0] waddr;
        logic [31:0]        wdata;
        logic [HASH_AW-1:0] raddr;
    } t_hash_req;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

@@ rtl/core/sha256_stream_hasher_core.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a stream of big-endian message words, eight digest words out.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+------------------------
//   in      | in  | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//   out     | out | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// An item that leaves its block open leaves the sequencer idle, so such items are taken back to back.
// A completed block loads the hash words from the hash RAM, runs 64 rounds at
// one per cycle, then adds back through the single hash RAM port pair.
// A last item runs one or two padding blocks, then reads, loads and presents each digest word.
// After reset a pass writes the eight initial hash words; input stalls.
// Output stall holds the digest word register and the sequencer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  shash_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output shash_pkg::t_out_item o_out_item
);
    import shash_pkg::*;

    `include "sha256_stream_hasher_core_assert.svh"

    logic              w_in_accept;
    logic              w_fill_clear;
    logic              w_block_full;
    t_fill_info        w_fill_info;
    t_buf_wr           w_buf_wr;
    logic [BUF_AW-1:0] w_buf_raddr;
    logic [31:0]       w_buf_rdata;
    t_hash_req         w_hash_req;
    logic [31:0]       w_hash_rdata;

    assign w_in_accept = i_in_valid && !o_in_stall;

    shash_fill u_fill (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_clear      (w_fill_clear),
        .i_item       (i_in_item),
        .o_buf_wr     (w_buf_wr),
        .o_block_full (w_block_full),
        .o_info       (w_fill_info)
    );

    shash_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (w_buf_wr.we),
        .i_waddr (w_buf_wr.addr),
        .i_wdata (w_buf_wr.data),
        .i_raddr (w_buf_raddr),
        .o_rdata (w_buf_rdata)
    );

    shash_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HASH_DEPTH)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (w_hash_req.we),
        .i_waddr (w_hash_req.waddr),
        .i_wdata (w_hash_req.wdata),
        .i_raddr (w_hash_req.raddr),
        .o_rdata (w_hash_rdata)
    );

    shash_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_in_accept),
        .i_is_last    (i_in_item.is_last),
        .i_block_full (w_block_full),
        .i_fill       (w_fill_info),
        .o_fill_clear (w_fill_clear),
        .o_buf_raddr  (w_buf_raddr),
        .i_buf_rdata  (w_buf_rdata),
        .o_hash       (w_hash_req),
        .i_hash_rdata (w_hash_rdata),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .o_busy       (o_in_stall)
    );

    `SHASH_ASSERT_IMPL(a_no_in_during_out, w_in_accept, !o_out_valid, "item taken during digest")
    `SHASH_ASSERT_IMPL(a_hash_wr_busy, w_hash_req.we, o_in_stall, "hash RAM written while idle")
    `SHASH_ASSERT_NEXT(a_digest_end, o_out_valid && !i_out_stall && o_out_item.last_word, !o_out_valid, "extra digest word")

endmodule

@@ rtl/core/shash_ram.sv @@
// ----------------------------------------------------------------------------
// shash_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module shash_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/shash_fill.sv @@
// ----------------------------------------------------------------------------
// shash_fill
// Byte packer: places item bytes into the block buffer, tracks the fill
// position, the open partial word and the running byte total.
// ----------------------------------------------------------------------------
module shash_fill (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_clear,
    input  shash_pkg::t_in_item   i_item,
    output shash_pkg::t_buf_wr    o_buf_wr,
    output logic                  o_block_full,
    output shash_pkg::t_fill_info o_info
);
    import shash_pkg::*;

    logic [FILL_W-1:0]  r_fill;
    logic [31:0]        r_part;
    logic [TOTAL_W-1:0] r_total;

    logic [2:0]        cnt;
    logic [1:0]        off;
    logic [2:0]        off_sum;
    logic [FILL_W:0]   sum;
    logic [31:0]       mword;
    logic [63:0]       merged;
    logic [31:0]       n_part;
    logic [31:0]       pad_bit;

    assign cnt     = (i_item.byte_count > 3'd4) ? 3'd4 : i_item.byte_count;
    assign off     = r_fill[1:0];
    assign off_sum = {1'b0, off} + cnt;
    assign sum     = {1'b0, r_fill} + {{(FILL_W-2){1'b0}}, cnt};

    always_comb begin
        case (cnt)
            3'd0:    mword = 32'h0;
            3'd1:    mword = {i_item.msg_word[31:24], 24'h0};
            3'd2:    mword = {i_item.msg_word[31:16], 16'h0};
            3'd3:    mword = {i_item.msg_word[31:8], 8'h0};
            default: mword = i_item.msg_word;
        endcase
    end

    assign merged = {r_part, 32'h0} | ({mword, 32'h0} >> {off, 3'b000});
    assign n_part = off_sum[2] ? merged[31:0] : merged[63:32];

    always_comb begin
        case (off)
            2'd0:    pad_bit = {PAD_BYTE, 24'h0};
            2'd1:    pad_bit = {8'h0, PAD_BYTE, 16'h0};
            2'd2:    pad_bit = {16'h0, PAD_BYTE, 8'h0};
            default: pad_bit = {24'h0, PAD_BYTE};
        endcase
    end

    assign o_buf_wr.we   = i_accept;
    assign o_buf_wr.addr = r_fill[FILL_W-1:2];
    assign o_buf_wr.data = merged[63:32];
    assign o_block_full  = sum[FILL_W];

    assign o_info.pad_idx  = r_fill[FILL_W-1:2];
    assign o_info.pad_word = r_part | pad_bit;
    assign o_info.bit_len  = {r_total, 3'b000};
    assign o_info.late_pad = (r_fill >= 6'd56);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fill  <= '0;
            r_part  <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_fill  <= sum[FILL_W-1:0];
            r_part  <= n_part;
            r_total <= r_total + {{(TOTAL_W-3){1'b0}}, cnt};
        end
    end

endmodule

@@ rtl/core/shash_engine.sv @@
// ----------------------------------------------------------------------------
// shash_engine
// Block sequencer: loads the hash words from RAM, runs 64 rounds with a
// 16-word schedule window, adds back into RAM and streams out the digest.
// ----------------------------------------------------------------------------
module shash_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_is_last,
    input  logic                          i_block_full,
    input  shash_pkg::t_fill_info         i_fill,
    output logic                          o_fill_clear,
    output logic [shash_pkg::BUF_AW-1:0]  o_buf_raddr,
    input  logic [31:0]                   i_buf_rdata,
    output shash_pkg::t_hash_req          o_hash,
    input  logic [31:0]                   i_hash_rdata,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output shash_pkg::t_out_item          o_out_item,
    output logic                          o_busy
);
    import shash_pkg::*;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_LOAD, S_ROUND, S_FINAL, S_EMIT_RD, S_EMIT_LD, S_EMIT_WT
    } t_state;

    typedef enum logic [1:0] {
        M_NORMAL, M_PAD, M_LEN
    } t_mode;

    t_state      r_state;
    t_mode       r_mode;
    logic        r_last;
    logic [3:0]  r_cnt;
    logic [5:0]  r_round;
    logic [31:0] r_v [8];
    logic [31:0] r_s [16];
    logic        r_ov;
    t_out_item   r_out;

    logic [BUF_AW-1:0] j;
    logic [31:0]       w_pick;
    logic [31:0]       w_sched;
    logic [31:0]       w_next;
    logic [31:0]       t1;
    logic [31:0]       t2;

    assign j = (r_state == S_LOAD) ? 4'd0 : r_round[3:0] + 4'd1;

    always_comb begin
        case (r_mode)
            M_NORMAL: w_pick = i_buf_rdata;
            M_PAD: begin
                if (j < i_fill.pad_idx) begin
                    w_pick = i_buf_rdata;
                end else if (j == i_fill.pad_idx) begin
                    w_pick = i_fill.pad_word;
                end else if (!i_fill.late_pad && j == 4'd14) begin
                    w_pick = i_fill.bit_len[63:32];
                end else if (!i_fill.late_pad && j == 4'd15) begin
                    w_pick = i_fill.bit_len[31:0];
                end else begin
                    w_pick = 32'h0;
                end
            end
            M_LEN: begin
                if (j == 4'd14) begin
                    w_pick = i_fill.bit_len[63:32];
                end else if (j == 4'd15) begin
                    w_pick = i_fill.bit_len[31:0];
                end else begin
                    w_pick = 32'h0;
                end
            end
            default: w_pick = 32'h0;
        endcase
    end

    assign w_sched = small_sigma1(r_s[14]) + r_s[9] + small_sigma0(r_s[1]) + r_s[0];
    assign w_next  = (r_round < 6'd15) ? w_pick : w_sched;

    assign t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + ROUND_K[r_round] + r_s[15];
    assign t2 = big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        case (r_state)
            S_LOAD:  o_buf_raddr = (r_cnt == 4'd8) ? 4'd1 : 4'd0;
            S_ROUND: o_buf_raddr = r_round[3:0] + 4'd2;
            default: o_buf_raddr = 4'd0;
        endcase
    end

    always_comb begin
        o_hash.we    = 1'b0;
        o_hash.waddr = r_cnt[HASH_AW-1:0];
        o_hash.wdata = HASH_INIT[r_cnt[HASH_AW-1:0]];
        o_hash.raddr = r_cnt[HASH_AW-1:0];
        case (r_state)
            S_INIT:    o_hash.we = 1'b1;
            S_EMIT_LD: o_hash.we = 1'b1;
            S_FINAL: begin
                o_hash.we    = (r_cnt != 4'd0);
                o_hash.waddr = r_cnt[HASH_AW-1:0] - 3'd1;
                o_hash.wdata = i_hash_rdata + r_v[0];
            end
            default: o_hash.we = 1'b0;
        endcase
    end

    assign o_fill_clear = (r_state == S_EMIT_WT) && !i_out_stall && (r_cnt == 4'd7);
    assign o_busy       = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_out_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= M_NORMAL;
            r_last  <= 1'b0;
            r_cnt   <= '0;
            r_round <= '0;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (r_cnt == 4'd7) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_IDLE: begin
                    if (i_accept) begin
                        r_last <= i_is_last;
                        r_cnt  <= '0;
                        if (i_block_full) begin
                            r_mode  <= M_NORMAL;
                            r_state <= S_LOAD;
                        end else if (i_is_last) begin
                            r_mode  <= M_PAD;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    if (r_cnt != 4'd0) begin
                        for (int i = 0; i < 7; i++) begin
                            r_v[i] <= r_v[i+1];
                        end
                        r_v[7] <= i_hash_rdata;
                    end
                    if (r_cnt == 4'd8) begin
                        for (int i = 0; i < 15; i++) begin
                            r_s[i] <= r_s[i+1];
                        end
                        r_s[15] <= w_pick;
                        r_round <= '0;
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_ROUND: begin
                    r_v[0] <= t1 + t2;
                    r_v[1] <= r_v[0];
                    r_v[2] <= r_v[1];
                    r_v[3] <= r_v[2];
                    r_v[4] <= r_v[3] + t1;
                    r_v[5] <= r_v[4];
                    r_v[6] <= r_v[5];
                    r_v[7] <= r_v[6];
                    for (int i = 0; i < 15; i++) begin
                        r_s[i] <= r_s[i+1];
                    end
                    r_s[15] <= w_next;
                    if (r_round == 6'd63) begin
                        r_round <= '0;
                        r_cnt   <= '0;
                        r_state <= S_FINAL;
                    end else begin
                        r_round <= r_round + 6'd1;
                    end
                end
                S_FINAL: begin
                    if (r_cnt != 4'd0) begin
                        for (int i = 0; i < 7; i++) begin
                            r_v[i] <= r_v[i+1];
                        end
                    end
                    if (r_cnt == 4'd8) begin
                        r_cnt <= '0;
                        case (r_mode)
                            M_NORMAL: begin
                                if (r_last) begin
                                    r_mode  <= M_PAD;
                                    r_state <= S_LOAD;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            M_PAD: begin
                                if (i_fill.late_pad) begin
                                    r_mode  <= M_LEN;
                                    r_state <= S_LOAD;
                                end else begin
                                    r_state <= S_EMIT_RD;
                                end
                            end
                            default: r_state <= S_EMIT_RD;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT_LD;
                S_EMIT_LD: begin
                    r_out.digest_word <= i_hash_rdata;
                    r_out.word_index  <= r_cnt[2:0];
                    r_out.last_word   <= (r_cnt == 4'd7);
                    r_ov              <= 1'b1;
                    r_state           <= S_EMIT_WT;
                end
                S_EMIT_WT: begin
                    if (!i_out_stall) begin
                        r_ov <= 1'b0;
                        if (r_cnt == 4'd7) begin
                            r_cnt   <= '0;
                            r_last  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 4'd1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives message words into sha256_stream_hasher_core and checks every digest
// word against a SHA-256 computed here, item by item, under random input gaps
// and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    import shash_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 210;
    localparam int TAIL_CYCLES = 300;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    sha256_stream_hasher_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // hash state mirrored from accepted items
    logic [31:0] chain_hash [8];
    logic [7:0]  block_bytes [64];
    int          block_fill;
    logic [60:0] msg_bytes;

    t_out_item   digest_q [$];
    t_out_item   want_word;

    int          err_count;
    int          cycle_count;
    int          items_sent;
    int          msgs_sent;
    int          words_checked;
    int          burst_left;
    bit          steady;
    int          hold_request;
    int          hold_left;
    int          rx_mode;
    int          rx_phase;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1, x;
        int          i;
        int          r;
        for (i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
        e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
        for (r = 0; r < 64; r++) begin
            if (r >= 16) begin
                x  = w[(r + 1) % 16];
                s0 = rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3);
                x  = w[(r + 14) % 16];
                s1 = rot_right(x, 17) ^ rot_right(x, 19) ^ (x >> 10);
                w[r % 16] = s1 + w[(r + 9) % 16] + s0 + w[r % 16];
            end
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
               + ((e & f) ^ (~e & g)) + SHA_K[r] + w[r % 16];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
        chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
    endfunction

    function automatic void restart_digest();
        int i;
        for (i = 0; i < 8; i++)
            chain_hash[i] = SHA_IV[i];
        for (i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        block_fill = 0;
        msg_bytes  = '0;
    endfunction

    function automatic void predict_digest(input t_in_item it);
        int          cnt;
        int          i;
        logic [63:0] bit_len;
        t_out_item   dw;
        cnt = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
        for (i = 0; i < cnt; i++) begin
            block_bytes[block_fill] = it.msg_word[31 - 8*i -: 8];
            block_fill++;
            if (block_fill == 64) begin
                hash_block();
                block_fill = 0;
            end
        end
        msg_bytes = msg_bytes + 61'(cnt);
        if (!it.is_last)
            return;
        block_bytes[block_fill] = PAD_MARK;
        for (i = block_fill + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
        // no room for the length: spill into one more block
        if (block_fill > 55) begin
            hash_block();
            for (i = 0; i < 64; i++)
                block_bytes[i] = 8'h00;
        end
        bit_len = {msg_bytes, 3'b000};
        for (i = 0; i < 8; i++)
            block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        hash_block();
        for (i = 0; i < 8; i++) begin
            dw.digest_word = chain_hash[i];
            dw.word_index  = 3'(i);
            dw.last_word   = (i == 7);
            digest_q.push_back(dw);
        end
        restart_digest();
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    function automatic t_in_item make_item(input logic [31:0] w, input int cnt, input bit last);
        t_in_item it;
        it.msg_word   = w;
        it.byte_count = 3'(cnt);
        it.is_last    = last;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        predict_digest(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic pace();
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                idle_cycles($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic send_message(input int n_full, input int last_cnt, input bit broken);
        int cnt;
        int i;
        for (i = 0; i < n_full; i++) begin
            cnt = 4;
            if (broken && $urandom_range(0, 3) == 0)
                cnt = $urandom_range(0, 7);
            send_item(make_item($urandom, cnt, 1'b0));
            pace();
        end
        send_item(make_item($urandom, last_cnt, 1'b1));
        pace();
        msgs_sent++;
    endtask

    task automatic wait_all_digests();
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_known_messages();
        send_item(make_item(32'hdeadbeef, 0, 1'b1));
        send_item(make_item(32'h61626300, 3, 1'b1));
        msgs_sent += 2;
    endtask

    task automatic test_count_cases();
        send_item(make_item(32'h01234567, 7, 1'b0));
        send_item(make_item(32'h89abcdef, 6, 1'b0));
        send_item(make_item(32'hfedcba98, 5, 1'b1));
        send_item(make_item(32'hffffffff, 1, 1'b0));
        idle_cycles(3);
        send_item(make_item(32'h00000000, 2, 1'b0));
        send_item(make_item(32'ha5a5a5a5, 3, 1'b0));
        send_item(make_item(32'h5a5a5a5a, 0, 1'b0));
        send_item(make_item(32'hffffffff, 4, 1'b1));
        msgs_sent += 2;
    endtask

    task automatic test_extra_pad_block();
        int i;
        for (i = 0; i < 14; i++)
            send_item(make_item(32'hffffffff, 4, 1'b0));
        send_item(make_item(32'h00000000, 0, 1'b1));
        msgs_sent++;
    endtask

    task automatic test_output_holdoff();
        steady = 1'b1;
        hold_request = 700;
        send_message(20, 3, 1'b0);
        send_message(20, 2, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        send_message($urandom_range(10, 18), $urandom_range(0, 4), 1'b0);
        wait_all_digests();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        send_message($urandom_range(0, 6), $urandom_range(0, 4), 1'b0);
    endtask

    task automatic test_random_stream();
        int n_full;
        int last_cnt;
        int pick;
        bit broken;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n_full = $urandom_range(0, 12);
            else if (pick < 9)
                n_full = $urandom_range(12, 18);
            else
                n_full = $urandom_range(19, 40);
            last_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            broken = ($urandom_range(0, 4) == 0);
            steady = ($urandom_range(0, 3) == 0);
            send_message(n_full, last_cnt, broken);
        end
        steady = 1'b0;
    endtask

    // receiver stall: long hold-off on request, else a changing pattern
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            case (rx_mode)
                0: begin
                    out_stall <= 1'b0;
                end
                1: begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    out_stall <= ((rx_phase % 7) < 3);
                end
            endcase
        end
        rx_phase++;
        if (rx_phase % 250 == 0)
            rx_mode = $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("digest word %08h with none pending",
                                          out_item.digest_word));
            end else begin
                want_word = digest_q.pop_front();
                if (out_item.digest_word !== want_word.digest_word)
                    report_mismatch($sformatf("digest_word %08h, want %08h",
                                              out_item.digest_word, want_word.digest_word));
                if (out_item.word_index !== want_word.word_index)
                    report_mismatch($sformatf("word_index %0d, want %0d",
                                              out_item.word_index, want_word.word_index));
                if (out_item.last_word !== want_word.last_word)
                    report_mismatch($sformatf("last_word %0b, want %0b",
                                              out_item.last_word, want_word.last_word));
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        err_count     = 0;
        cycle_count   = 0;
        items_sent    = 0;
        msgs_sent     = 0;
        words_checked = 0;
        burst_left    = 4;
        steady        = 1'b0;
        hold_request  = 0;
        hold_left     = 0;
        rx_mode       = 0;
        rx_phase      = 0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        i_rst_n       = 1'b0;
        restart_digest();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_known_messages();
        test_count_cases();
        test_extra_pad_block();
        rx_mode = 1;
        test_output_holdoff();
        test_sender_pause();
        test_random_stream();

        wait_all_digests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d message words in %0d messages, %0d digest words checked",
                 items_sent, msgs_sent, words_checked);
        $display("summary: empty, short, saturated-count and spill-block messages, %0d errors",
                 err_count);
        if (err_count == 0 && digest_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
